### design/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared definitions of the LRU key-value cache
// Sizes, state codes and the structs that pass between the sequencer and
// the entry store.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 16;
    localparam int CAP_BITS   = 5;

    // Slot index, and a count that can hold ENTRIES itself (ages, capacity).
    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_DATA_BITS = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((1 + VALUE_BITS + 7) / 8) * 8;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_SET = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESULT
    } lkv_state_t;

    // One slot as seen at the scan read port.
    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [CNT_BITS-1:0]   age;
    } entry_rd_t;

    // Update command issued once per set item, after the scan.
    typedef struct packed {
        logic                  update;
        logic                  is_hit;
        logic [IDX_BITS-1:0]   hit_slot;
        logic [CNT_BITS-1:0]   old_age;
        logic [IDX_BITS-1:0]   free_slot;
        logic [CNT_BITS-1:0]   cap;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } store_cmd_t;

endpackage

### design/lkv_store.sv
// ----------------------------------------------------------------------------
// lkv_store: entry store of the LRU key-value cache
// Holds keys, values, ages and valid bits. One slot is read per cycle for the
// scan; a set command applies the recency update and eviction to all slots.
// ----------------------------------------------------------------------------
module lkv_store (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [lkv_pkg::IDX_BITS-1:0] rd_idx,
    input  lkv_pkg::store_cmd_t          cmd,
    output lkv_pkg::entry_rd_t           rd
);
    import lkv_pkg::*;

    logic [KEY_BITS-1:0]   key_mem_reg   [ENTRIES];
    logic [VALUE_BITS-1:0] value_mem_reg [ENTRIES];
    logic [CNT_BITS-1:0]   age_reg       [ENTRIES];
    logic [CNT_BITS-1:0]   age_next      [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    valid_next;

    // Scan read port.
    assign rd.valid = valid_reg[rd_idx];
    assign rd.key   = key_mem_reg[rd_idx];
    assign rd.value = value_mem_reg[rd_idx];
    assign rd.age   = age_reg[rd_idx];

    // Per-slot age step and eviction; each slot depends only on its own age.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (cmd.is_hit) begin
                if (IDX_BITS'(i) == cmd.hit_slot) begin
                    age_next[i] = '0;
                end else if (age_reg[i] < cmd.old_age) begin
                    age_next[i] = age_reg[i] + CNT_BITS'(1);
                end else begin
                    age_next[i] = age_reg[i];
                end
            end else begin
                age_next[i] = age_reg[i] + CNT_BITS'(1);
            end
            valid_next[i] = valid_reg[i] && (age_next[i] < cmd.cap);
        end
        // A new key takes the chosen free slot as the most recent entry.
        if (!cmd.is_hit) begin
            valid_next[cmd.free_slot] = 1'b1;
            age_next[cmd.free_slot]   = '0;
        end
    end

    // Valid bits are control state and clear at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.update) begin
            valid_reg <= valid_next;
        end
    end

    // Payload and ages; slots that are not valid are never trusted.
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            for (int i = 0; i < ENTRIES; i++) begin
                age_reg[i] <= age_next[i];
            end
            if (cmd.is_hit) begin
                value_mem_reg[cmd.hit_slot] <= cmd.value;
            end else begin
                key_mem_reg[cmd.free_slot]   <= cmd.key;
                value_mem_reg[cmd.free_slot] <= cmd.value;
            end
        end
    end

endmodule

### design/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core: fully associative key-value cache with LRU
// replacement
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser is the action (0 get, 1 set),
// s_tdata carries the key and the value. A get returns one transfer on the
// m_ stream with the hit flag and the stored value (zero on a miss). A set
// returns nothing; it updates an existing key or inserts a new one as the
// most recent entry, evicting the least recent entries beyond the capacity.
// The capacity register is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Zero acts as one and values above the slot count saturate.
// Each request is scanned by one shared key comparator that visits one slot
// per cycle; then an update step applies a set, or a result step loads the
// result register for a get, before the next request is accepted.
// A result waits in the output register while the receiver stalls, and the
// next request is accepted meanwhile; a later get holds at its result step
// until the register is free.
// Reset clears all valid bits, empties the output and sets capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: capacity register.
    input  logic                            cfg_wr_en,
    input  logic [lkv_pkg::CAP_BITS-1:0]    cfg_wr_data,
    // Request stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lkv_pkg::S_DATA_BITS-1:0] s_tdata,  // key, value
    input  logic                            s_tuser,  // action
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lkv_pkg::M_DATA_BITS-1:0] m_tdata   // hit, value_out, zero pad
);
    import lkv_pkg::*;

    lkv_state_t state_reg, state_next;

    logic [CAP_BITS-1:0]   cap_reg;
    logic [CNT_BITS-1:0]   cap_eff;
    logic                  action_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [IDX_BITS-1:0]   idx_reg;

    logic                  found_reg;
    logic [IDX_BITS-1:0]   slot_reg;
    logic [CNT_BITS-1:0]   old_age_reg;
    logic [VALUE_BITS-1:0] hit_val_reg;
    logic                  free_found_reg;
    logic [IDX_BITS-1:0]   free_slot_reg;

    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic [VALUE_BITS-1:0] m_value_reg;

    logic       accept;
    logic       scan_last;
    logic       load_out;
    logic       match;
    logic       free_here;
    entry_rd_t  rd;
    store_cmd_t cmd;

    // Effective capacity: zero acts as one, large values saturate.
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_BITS'(1);
        end else if (CMP_BITS'(cap_reg) > CMP_BITS'(ENTRIES)) begin
            cap_eff = CNT_BITS'(ENTRIES);
        end else begin
            cap_eff = CNT_BITS'(cap_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Shared compare unit: one slot per scan cycle.
    assign match     = rd.valid && (rd.key == key_reg);
    assign free_here = !rd.valid || ((rd.age + CNT_BITS'(1)) >= cap_eff);
    assign scan_last = (idx_reg == IDX_BITS'(ENTRIES - 1));
    assign accept    = s_tvalid && s_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = (action_reg == ACT_SET) ? ST_UPDATE : ST_RESULT;
                end
            end
            ST_UPDATE: begin
                state_next = ST_IDLE;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        load_out = (state_reg == ST_RESULT) && (!m_valid_reg || m_tready);

        cmd.update    = (state_reg == ST_UPDATE);
        cmd.is_hit    = found_reg;
        cmd.hit_slot  = slot_reg;
        cmd.old_age   = old_age_reg;
        cmd.free_slot = free_slot_reg;
        cmd.cap       = cap_eff;
        cmd.key       = key_reg;
        cmd.value     = value_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Request capture and scan bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (accept) begin
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (state_reg == ST_SCAN) begin
            idx_reg <= idx_reg + IDX_BITS'(1);
            if (match && !found_reg) begin
                found_reg <= 1'b1;
            end
            if (free_here && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg <= s_tuser;
            key_reg    <= s_tdata[KEY_BITS-1:0];
            value_reg  <= s_tdata[KEY_BITS +: VALUE_BITS];
        end
        if (state_reg == ST_SCAN) begin
            if (match && !found_reg) begin
                slot_reg    <= idx_reg;
                old_age_reg <= rd.age;
                hit_val_reg <= rd.value;
            end
            if (free_here && !free_found_reg) begin
                free_slot_reg <= idx_reg;
            end
        end
    end

    lkv_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (idx_reg),
        .cmd     (cmd),
        .rd      (rd)
    );

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_hit_reg   <= found_reg;
            m_value_reg <= found_reg ? hit_val_reg : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_BITS'({m_value_reg, m_hit_reg});

endmodule

### design/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker: port-level checks of the LRU key-value cache
// Watches the top-level ports and flags behavior the cache must not show.
// ----------------------------------------------------------------------------
module lkv_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lkv_pkg::M_DATA_BITS-1:0] m_tdata
);
    import lkv_pkg::*;

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // After a request transfer the block is busy scanning.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while a scan was starting");

    // A miss carries a zero value and zero padding.
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[M_DATA_BITS-1:1] == '0)
        else $error("miss result with nonzero value");

    // No result is left over from before reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind lru_key_value_cache_core lkv_checker u_lkv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the LRU key-value cache core
// Get and set requests are queued and driven on the request stream, with
// random gaps on both sides. A software copy of the cache predicts every get
// result, and each result transfer is compared with the oldest prediction.
// The capacity register is changed between phases, down to one entry and
// beyond the slot count.
// ----------------------------------------------------------------------------
module tb;
    import lkv_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int IDLE_GAP       = ENTRIES + 8;
    localparam int NUM_PHASES     = 9;
    localparam int PHASE_ITEMS    = 65;
    localparam int HOLD_CYCLES    = 300;
    localparam int PRESSURE_PHASE = 6;

    typedef enum int {
        MODE_SLOW_RECV,
        MODE_SLOW_SEND,
        MODE_STEADY
    } idle_mode_t;

    typedef struct {
        logic                  action;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } request_t;

    typedef struct {
        logic                  hit;
        logic [VALUE_BITS-1:0] value;
    } lookup_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CAP_BITS-1:0]    cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata     = '0;
    logic                   s_tuser     = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;

    // Requests waiting to be driven, and get results still to arrive.
    request_t request_queue[$];
    lookup_t  lookup_results[$];

    idle_mode_t idle_mode = MODE_SLOW_RECV;
    int         phase_no  = -1;
    bit         req_taken = 1'b0;
    int         queued_count = 0;
    int         accepted_count = 0;
    int         fail_count = 0;
    int         get_count = 0;
    int         set_count = 0;
    int         hit_count = 0;
    int         capacity_writes = 0;
    int         cycle_count = 0;
    int         hold_left = 0;
    bit         hold_used = 1'b0;

    // Software copy of the cache.
    logic [KEY_BITS-1:0]   slot_key[ENTRIES];
    logic [VALUE_BITS-1:0] slot_val[ENTRIES];
    bit                    slot_used[ENTRIES];
    int unsigned           slot_age[ENTRIES];
    logic [CAP_BITS-1:0]   cap_reg;

    lru_key_value_cache_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Zero means one entry; values above the slot count saturate.
    function automatic int unsigned live_capacity();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > ENTRIES)
            return ENTRIES;
        return 32'(cap_reg);
    endfunction

    function automatic int find_slot(logic [KEY_BITS-1:0] key);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic lookup_t cache_lookup(logic [KEY_BITS-1:0] key);
        lookup_t r;
        int      slot;
        slot = find_slot(key);
        r.hit = (slot >= 0);
        r.value = (slot >= 0) ? slot_val[slot] : '0;
        return r;
    endfunction

    function automatic void cache_store(logic [KEY_BITS-1:0] key,
                                        logic [VALUE_BITS-1:0] value);
        int          slot;
        int unsigned old_age;
        int unsigned cap;
        bit          placed;
        slot = find_slot(key);
        cap = live_capacity();
        placed = 1'b0;
        if (slot >= 0) begin
            // Entries newer than the updated one age by one step.
            old_age = slot_age[slot];
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i] && slot_age[i] < old_age)
                    slot_age[i]++;
            slot_age[slot] = 0;
            slot_val[slot] = value;
        end else begin
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i])
                    slot_age[i]++;
        end
        // Drop everything that now lies beyond the capacity.
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_age[i] >= cap)
                slot_used[i] = 1'b0;
        // A new key takes the lowest free slot.
        if (slot < 0) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (!slot_used[i] && !placed) begin
                    slot_used[i] = 1'b1;
                    slot_key[i] = key;
                    slot_val[i] = value;
                    slot_age[i] = 0;
                    placed = 1'b1;
                end
            end
        end
    endfunction

    // Sender: offers the next queued request, with random gaps.
    always @(negedge aclk) begin : request_driver
        request_t    req;
        int unsigned idle_pct;
        idle_pct = (idle_mode == MODE_SLOW_RECV) ? 34 :
                   (idle_mode == MODE_SLOW_SEND) ? 87 : 0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                req = request_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= req.action;
                s_tdata <= S_DATA_BITS'({req.value, req.key});
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off in one phase.
    always @(negedge aclk) begin : result_receiver
        int unsigned idle_pct;
        idle_pct = (idle_mode == MODE_SLOW_RECV) ? 87 :
                   (idle_mode == MODE_SLOW_SEND) ? 34 : 0;
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_used && phase_no == PRESSURE_PHASE) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Monitor: checks each result transfer and predicts each accepted request.
    always @(posedge aclk) begin : cache_monitor
        lookup_t               want;
        logic [KEY_BITS-1:0]   in_key;
        logic [VALUE_BITS-1:0] in_val;
        if (!aresetn) begin
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            cap_reg = CAP_RESET;
            req_taken <= 1'b0;
        end else begin
            if (cfg_wr_en)
                cap_reg = cfg_wr_data;

            if (m_tvalid && m_tready) begin
                if (lookup_results.size() == 0) begin
                    $error("result transfer with no get pending: m_tdata=%h", m_tdata);
                    fail_count++;
                end else begin
                    want = lookup_results.pop_front();
                    if (want.hit)
                        hit_count++;
                    if (m_tdata[0] !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[1 +: VALUE_BITS] !== want.value) begin
                        $error("value_out: expected %h, got %h",
                               want.value, m_tdata[1 +: VALUE_BITS]);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                accepted_count++;
                in_key = s_tdata[0 +: KEY_BITS];
                in_val = s_tdata[KEY_BITS +: VALUE_BITS];
                if (s_tuser == ACT_GET) begin
                    lookup_results.push_back(cache_lookup(in_key));
                    get_count++;
                end else begin
                    cache_store(in_key, in_val);
                    set_count++;
                end
            end
            req_taken <= s_tvalid && s_tready;
        end
    end

    // Run limit.
    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("lru_key_value_cache_core test failed");
            $finish;
        end
    end

    task automatic queue_request(logic action, logic [KEY_BITS-1:0] key,
                                 logic [VALUE_BITS-1:0] value);
        request_t req;
        req.action = action;
        req.key = key;
        req.value = value;
        request_queue.push_back(req);
        queued_count++;
    endtask

    // Waits until every request went in and every get came back, then lets a
    // trailing set finish its scan.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (accepted_count != queued_count || lookup_results.size() != 0);
        repeat (IDLE_GAP) @(negedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_BITS-1:0] cap);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        capacity_writes++;
    endtask

    initial begin : stimulus
        logic [KEY_BITS-1:0] key_pool[$];
        logic [KEY_BITS-1:0] k;
        int                  pool_size;
        int                  phase_caps[NUM_PHASES] = '{4, 1, 31, 0, 16, 7, 2, 17, 12};

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Empty store, lowest and highest keys and values, overwrite of a key.
        queue_request(ACT_GET, '0, '0);
        queue_request(ACT_SET, '0, '1);
        queue_request(ACT_GET, '0, '0);
        queue_request(ACT_SET, '1, '0);
        queue_request(ACT_GET, '1, '1);
        queue_request(ACT_SET, '0, VALUE_BITS'('h1234));
        queue_request(ACT_GET, '0, '0);
        wait_idle();

        // Capacity two, with two keys already stored before the first insert;
        // an update refreshes recency so the other key is evicted next.
        write_capacity(CAP_BITS'(2));
        queue_request(ACT_SET, KEY_BITS'(10), VALUE_BITS'(100));
        queue_request(ACT_SET, KEY_BITS'(11), VALUE_BITS'(110));
        queue_request(ACT_SET, KEY_BITS'(12), VALUE_BITS'(120));
        queue_request(ACT_GET, KEY_BITS'(10), '0);
        queue_request(ACT_GET, KEY_BITS'(11), '0);
        queue_request(ACT_SET, KEY_BITS'(11), VALUE_BITS'(111));
        queue_request(ACT_SET, KEY_BITS'(13), VALUE_BITS'(130));
        queue_request(ACT_GET, KEY_BITS'(12), '0);
        queue_request(ACT_GET, KEY_BITS'(11), '0);
        queue_request(ACT_GET, KEY_BITS'(13), '0);
        wait_idle();

        // Capacity zero acts as one: gets evict nothing, the next set does.
        write_capacity(CAP_BITS'(0));
        queue_request(ACT_GET, KEY_BITS'(11), '0);
        queue_request(ACT_GET, KEY_BITS'(13), '0);
        queue_request(ACT_SET, KEY_BITS'(14), VALUE_BITS'(140));
        queue_request(ACT_GET, KEY_BITS'(11), '0);
        queue_request(ACT_GET, KEY_BITS'(13), '0);
        queue_request(ACT_GET, KEY_BITS'(14), '0);
        wait_idle();

        // Random phases: keys mostly from a small pool so that hits, updates
        // and evictions are frequent, with some fully random keys mixed in.
        for (int p = 0; p < NUM_PHASES; p++) begin
            phase_no = p;
            idle_mode = (p < 3) ? MODE_SLOW_RECV : (p < 6) ? MODE_SLOW_SEND : MODE_STEADY;
            write_capacity(CAP_BITS'(phase_caps[p]));
            key_pool.delete();
            pool_size = $urandom_range(ENTRIES + 8, 2);
            repeat (pool_size)
                key_pool.push_back(KEY_BITS'($urandom));
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(99) < 85)
                    k = key_pool[$urandom_range(pool_size - 1)];
                else
                    k = KEY_BITS'($urandom);
                queue_request(logic'($urandom_range(1)), k, VALUE_BITS'($urandom));
            end
            wait_idle();
        end

        $display("Ran %0d sets and %0d gets (%0d hits) across %0d capacity settings,",
                 set_count, get_count, hit_count, capacity_writes + 1);
        $display("with random gaps on both streams and a %0d-cycle result hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("lru_key_value_cache_core test passed");
        else
            $display("lru_key_value_cache_core test failed");
        $finish;
    end

endmodule

### filelist.f
design/lkv_pkg.sv
design/lkv_store.sv
design/lru_key_value_cache_core.sv
design/lkv_checker.sv
tb/sv/tb.sv
